[design/lps_pkg.sv]
// Shared types and constants for the lane pair selector.
// No dependencies; imported by lane_pair_selector_unit.
`default_nettype none

package lps_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int OFFSET_BITS    = 10;
	localparam int NUM_POINTS     = 8;
	localparam int NUM_OFFSETS    = 4;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [OFFSET_BITS-1:0] OFFSET_POINT0_RST = OFFSET_BITS'(120);
	localparam logic [OFFSET_BITS-1:0] OFFSET_POINT1_RST = OFFSET_BITS'(200);
	localparam logic [OFFSET_BITS-1:0] OFFSET_POINT2_RST = OFFSET_BITS'(280);
	localparam logic [OFFSET_BITS-1:0] OFFSET_POINT3_RST = OFFSET_BITS'(400);

	// point order within a spline: sx, sy, 2x, 2y, 3x, 3y, ex, ey
	localparam int PT_START_X = 0;
	localparam int PT_START_Y = 1;
	localparam int PT_END_X   = 6;
	localparam int PT_END_Y   = 7;

	typedef enum logic {
		SIDE_LEFT  = 1'b0,
		SIDE_RIGHT = 1'b1
	} side_t;

	localparam int PAIR_QDEPTH = 2;

endpackage

`default_nettype wire

[design/lane_pair_selector_unit.sv]
// Lane pair selector: keeps the best left and right spline of a frame and
// emits the pair on the last item. Depends on lps_pkg.
`default_nettype none

//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  in      | in_valid / in_stall   | has_spline, 8 points, frame_last
//  out     | out_valid / out_stall | lane_side, synthesized, 8 points, pair_last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle unless stalled; the input register feeds the lane state.
//  A frame end with a lane seen pushes a left/right pair into a two-deep queue;
//  each pair leaves over two output transfers, so frame ends set the output rate.
//  The last item of a frame waits in the input register while the queue is full.
//  Reset clears the seen flags, the queue and restores the offset registers.

module lane_pair_selector_unit
	import lps_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          has_spline,
	input  wire  signed [COORD_BITS-1:0] start_x,
	input  wire  signed [COORD_BITS-1:0] start_y,
	input  wire  signed [COORD_BITS-1:0] second_x,
	input  wire  signed [COORD_BITS-1:0] second_y,
	input  wire  signed [COORD_BITS-1:0] third_x,
	input  wire  signed [COORD_BITS-1:0] third_y,
	input  wire  signed [COORD_BITS-1:0] end_x,
	input  wire  signed [COORD_BITS-1:0] end_y,
	input  wire                          frame_last,

	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         lane_side,
	output logic                         synthesized,
	output logic signed [COORD_BITS:0]   out_start_x,
	output logic signed [COORD_BITS:0]   out_start_y,
	output logic signed [COORD_BITS:0]   out_second_x,
	output logic signed [COORD_BITS:0]   out_second_y,
	output logic signed [COORD_BITS:0]   out_third_x,
	output logic signed [COORD_BITS:0]   out_third_y,
	output logic signed [COORD_BITS:0]   out_end_x,
	output logic signed [COORD_BITS:0]   out_end_y,
	output logic                         pair_last,

	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [OFFSET_BITS-1:0]       cfg_data
);

	localparam int OUT_W = COORD_BITS + 1;
	localparam int SUM_W = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 2;
	localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(1 << (OUT_W - 1)));

	// configuration
	logic [OFFSET_BITS-1:0] offset_q [NUM_OFFSETS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q[0] <= OFFSET_POINT0_RST;
			offset_q[1] <= OFFSET_POINT1_RST;
			offset_q[2] <= OFFSET_POINT2_RST;
			offset_q[3] <= OFFSET_POINT3_RST;
		end else if (cfg_valid && cfg_ready) begin
			offset_q[cfg_index] <= cfg_data;
		end
	end

	// input register
	logic                         valid_s1;
	logic                         has_spline_s1;
	logic                         frame_last_s1;
	logic signed [COORD_BITS-1:0] pts_s1 [NUM_POINTS];
	logic                         in_xfer;
	logic                         s1_go;
	logic                         s1_fire;

	// lane state
	logic                         left_seen_q;
	logic                         right_seen_q;
	logic signed [COORD_BITS-1:0] left_pts_q  [NUM_POINTS];
	logic signed [COORD_BITS-1:0] right_pts_q [NUM_POINTS];

	// pair queue
	logic                         q_head_q;
	logic                         q_tail_q;
	logic [1:0]                   q_cnt_q;
	logic                         half_q;
	logic signed [OUT_W-1:0]      q_pts_q   [PAIR_QDEPTH][2][NUM_POINTS];
	logic                         q_synth_q [PAIR_QDEPTH][2];
	logic                         q_full;
	logic                         out_xfer;
	logic                         pop;
	logic                         push;

	assign q_full   = (q_cnt_q == 2'(PAIR_QDEPTH));
	assign s1_go    = !frame_last_s1 || !q_full;
	assign s1_fire  = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			has_spline_s1 <= has_spline;
			frame_last_s1 <= frame_last;
			pts_s1[0]     <= start_x;
			pts_s1[1]     <= start_y;
			pts_s1[2]     <= second_x;
			pts_s1[3]     <= second_y;
			pts_s1[4]     <= third_x;
			pts_s1[5]     <= third_y;
			pts_s1[6]     <= end_x;
			pts_s1[7]     <= end_y;
		end
	end

	// classify, select, build the pair
	logic                         is_left;
	logic                         take_left;
	logic                         take_right;
	logic                         nl_seen;
	logic                         nr_seen;
	logic signed [COORD_BITS-1:0] nl_pts [NUM_POINTS];
	logic signed [COORD_BITS-1:0] nr_pts [NUM_POINTS];
	logic signed [OUT_W-1:0]      pair_pts [2][NUM_POINTS];
	logic signed [SUM_W-1:0]      l_ext;
	logic signed [SUM_W-1:0]      r_ext;
	logic signed [SUM_W-1:0]      off_ext;
	logic signed [SUM_W-1:0]      l_sum;
	logic signed [SUM_W-1:0]      r_sum;
	logic signed [OUT_W-1:0]      l_sat;
	logic signed [OUT_W-1:0]      r_sat;

	always_comb begin
		is_left    = (pts_s1[PT_END_X] < pts_s1[PT_START_X]) &&
		             (pts_s1[PT_END_Y] >= pts_s1[PT_START_Y]);
		take_left  = has_spline_s1 && is_left &&
		             (!left_seen_q || (pts_s1[PT_START_X] > left_pts_q[PT_START_X]));
		take_right = has_spline_s1 && !is_left &&
		             (!right_seen_q || (pts_s1[PT_END_X] < right_pts_q[PT_END_X]));
		nl_seen    = left_seen_q || take_left;
		nr_seen    = right_seen_q || take_right;
		for (int k = 0; k < NUM_POINTS; k++) begin
			nl_pts[k] = take_left  ? pts_s1[k] : left_pts_q[k];
			nr_pts[k] = take_right ? pts_s1[k] : right_pts_q[k];
		end
		l_ext   = '0;
		r_ext   = '0;
		off_ext = '0;
		l_sum   = '0;
		r_sum   = '0;
		l_sat   = '0;
		r_sat   = '0;
		for (int k = 0; k < NUM_POINTS; k++) begin
			l_ext = {{(SUM_W - COORD_BITS){nl_pts[k][COORD_BITS-1]}}, nl_pts[k]};
			r_ext = {{(SUM_W - COORD_BITS){nr_pts[k][COORD_BITS-1]}}, nr_pts[k]};
			if (k % 2 == 0) begin
				off_ext = {{(SUM_W - OFFSET_BITS){1'b0}}, offset_q[k / 2]};
			end else begin
				off_ext = '0;
			end
			l_sum = r_ext - off_ext;
			r_sum = l_ext + off_ext;
			if (l_sum > OUT_MAX) begin
				l_sat = OUT_MAX[OUT_W-1:0];
			end else if (l_sum < OUT_MIN) begin
				l_sat = OUT_MIN[OUT_W-1:0];
			end else begin
				l_sat = l_sum[OUT_W-1:0];
			end
			if (r_sum > OUT_MAX) begin
				r_sat = OUT_MAX[OUT_W-1:0];
			end else if (r_sum < OUT_MIN) begin
				r_sat = OUT_MIN[OUT_W-1:0];
			end else begin
				r_sat = r_sum[OUT_W-1:0];
			end
			pair_pts[SIDE_LEFT][k]  = nl_seen ? l_ext[OUT_W-1:0] : l_sat;
			pair_pts[SIDE_RIGHT][k] = nr_seen ? r_ext[OUT_W-1:0] : r_sat;
		end
	end

	assign push = s1_fire && frame_last_s1 && (nl_seen || nr_seen);

	// lane state update; a frame end drops both sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_seen_q  <= 1'b0;
			right_seen_q <= 1'b0;
		end else if (s1_fire) begin
			left_seen_q  <= nl_seen && !frame_last_s1;
			right_seen_q <= nr_seen && !frame_last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			left_pts_q  <= nl_pts;
			right_pts_q <= nr_pts;
		end
	end

	// pair queue: left half first, then right half
	assign out_valid = (q_cnt_q != 2'd0);
	assign out_xfer  = out_valid && !out_stall;
	assign pop       = out_xfer && half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= 1'b0;
			q_tail_q <= 1'b0;
			q_cnt_q  <= 2'd0;
			half_q   <= 1'b0;
		end else begin
			if (out_xfer) begin
				half_q <= !half_q;
			end
			if (pop) begin
				q_head_q <= !q_head_q;
			end
			if (push) begin
				q_tail_q <= !q_tail_q;
			end
			unique case ({push, pop})
				2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
				2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_pts_q[q_tail_q]               <= pair_pts;
			q_synth_q[q_tail_q][SIDE_LEFT]  <= !nl_seen;
			q_synth_q[q_tail_q][SIDE_RIGHT] <= !nr_seen;
		end
	end

	assign lane_side    = half_q;
	assign pair_last    = half_q;
	assign synthesized  = q_synth_q[q_head_q][half_q];
	assign out_start_x  = q_pts_q[q_head_q][half_q][0];
	assign out_start_y  = q_pts_q[q_head_q][half_q][1];
	assign out_second_x = q_pts_q[q_head_q][half_q][2];
	assign out_second_y = q_pts_q[q_head_q][half_q][3];
	assign out_third_x  = q_pts_q[q_head_q][half_q][4];
	assign out_third_y  = q_pts_q[q_head_q][half_q][5];
	assign out_end_x    = q_pts_q[q_head_q][half_q][6];
	assign out_end_y    = q_pts_q[q_head_q][half_q][7];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= 2'(PAIR_QDEPTH))
		else $error("pair queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full || pop))
		else $error("pair pushed into full queue");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_last_s1) |=> (!left_seen_q && !right_seen_q))
		else $error("lane state kept across frame end");

	a_right_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !half_q) |=> (out_valid && half_q))
		else $error("right lane missing after left lane");

	a_one_real_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(q_synth_q[q_head_q][SIDE_LEFT] && q_synth_q[q_head_q][SIDE_RIGHT]))
		else $error("pair with both sides synthesized");

endmodule

`default_nettype wire

[dv/lane_pair_checker.sv]
// Checker for lane_pair_selector_unit: watches the config, input and output channels,
// predicts each frame's left/right lane pair and compares every output transfer.
// Depends on lps_pkg.
`default_nettype none

module lane_pair_checker
	import lps_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,

	input  wire                   in_valid,
	input  wire                   in_stall,
	input  wire                   has_spline,
	input  wire  signed [CB-1:0]  start_x,
	input  wire  signed [CB-1:0]  start_y,
	input  wire  signed [CB-1:0]  second_x,
	input  wire  signed [CB-1:0]  second_y,
	input  wire  signed [CB-1:0]  third_x,
	input  wire  signed [CB-1:0]  third_y,
	input  wire  signed [CB-1:0]  end_x,
	input  wire  signed [CB-1:0]  end_y,
	input  wire                   frame_last,

	input  wire                   out_valid,
	input  wire                   out_stall,
	input  wire                   lane_side,
	input  wire                   synthesized,
	input  wire  signed [CB:0]    out_start_x,
	input  wire  signed [CB:0]    out_start_y,
	input  wire  signed [CB:0]    out_second_x,
	input  wire  signed [CB:0]    out_second_y,
	input  wire  signed [CB:0]    out_third_x,
	input  wire  signed [CB:0]    out_third_y,
	input  wire  signed [CB:0]    out_end_x,
	input  wire  signed [CB:0]    out_end_y,
	input  wire                   pair_last,

	input  wire                   cfg_valid,
	input  wire                   cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [OFFSET_BITS-1:0]  cfg_data,

	output int                    lanes_waiting,
	output int                    fail_count,
	output int                    lanes_compared,
	output int                    lanes_synth
);

	localparam int OUT_MAX = (1 << CB) - 1;
	localparam int OUT_MIN = -(1 << CB);

	typedef struct packed {
		side_t                      side;
		logic                       synth;
		logic [NUM_POINTS-1:0][CB:0] pts;
		logic                       last;
	} lane_rec_t;

	lane_rec_t             expected_lanes [$];
	lane_rec_t             want;
	logic [OFFSET_BITS-1:0] lane_offset [NUM_OFFSETS];
	logic                  have_left;
	logic                  have_right;
	logic signed [CB-1:0]  best_left  [NUM_POINTS];
	logic signed [CB-1:0]  best_right [NUM_POINTS];
	logic signed [CB-1:0]  in_pts     [NUM_POINTS];
	logic signed [CB:0]    got_pts    [NUM_POINTS];
	logic                  goes_left;
	int                    mismatches;
	int                    compared;
	int                    synth_seen;
	string                 point_name [NUM_POINTS] = '{"out_start_x", "out_start_y",
		"out_second_x", "out_second_y", "out_third_x", "out_third_y", "out_end_x", "out_end_y"};

	function automatic lane_rec_t make_lane(side_t side, logic synth,
			logic signed [CB-1:0] src [NUM_POINTS], int shift, logic last);
		lane_rec_t r;
		int v;
		r.side  = side;
		r.synth = synth;
		r.last  = last;
		for (int k = 0; k < NUM_POINTS; k++) begin
			v = int'(src[k]);
			if (k % 2 == 0)
				v = v + shift * int'(lane_offset[k / 2]);
			if (v > OUT_MAX)
				v = OUT_MAX;
			else if (v < OUT_MIN)
				v = OUT_MIN;
			r.pts[k] = v[CB:0];
		end
		return r;
	endfunction

	task automatic add_lane(lane_rec_t r);
		expected_lanes.insert(expected_lanes.size(), r);
	endtask

	task automatic check_field(string name, int expv, int gotv);
		if (expv != gotv) begin
			$error("%s: expected %0d, got %0d", name, expv, gotv);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_left      = 1'b0;
			have_right     = 1'b0;
			lane_offset[0] = OFFSET_POINT0_RST;
			lane_offset[1] = OFFSET_POINT1_RST;
			lane_offset[2] = OFFSET_POINT2_RST;
			lane_offset[3] = OFFSET_POINT3_RST;
			expected_lanes.delete();
			mismatches     = 0;
			compared       = 0;
			synth_seen     = 0;
			lanes_waiting  <= 0;
			fail_count     <= 0;
			lanes_compared <= 0;
			lanes_synth    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				lane_offset[cfg_index] = cfg_data;

			if (out_valid && !out_stall) begin
				got_pts = '{out_start_x, out_start_y, out_second_x, out_second_y,
					out_third_x, out_third_y, out_end_x, out_end_y};
				if (expected_lanes.size() == 0) begin
					$error("lane transfer with none expected: lane_side %0d", lane_side);
					mismatches++;
				end else begin
					want = expected_lanes.pop_front();
					check_field("lane_side", int'(want.side), int'(lane_side));
					check_field("synthesized", int'(want.synth), int'(synthesized));
					for (int k = 0; k < NUM_POINTS; k++)
						check_field(point_name[k], int'($signed(want.pts[k])), int'(got_pts[k]));
					check_field("pair_last", int'(want.last), int'(pair_last));
					compared++;
					if (want.synth)
						synth_seen++;
				end
			end

			if (in_valid && !in_stall) begin
				in_pts = '{start_x, start_y, second_x, second_y, third_x, third_y, end_x, end_y};
				if (has_spline) begin
					goes_left = (in_pts[PT_END_X] < in_pts[PT_START_X]) &&
						(in_pts[PT_END_Y] >= in_pts[PT_START_Y]);
					if (goes_left) begin
						if (!have_left || in_pts[PT_START_X] > best_left[PT_START_X]) begin
							best_left = in_pts;
							have_left = 1'b1;
						end
					end else if (!have_right || in_pts[PT_END_X] < best_right[PT_END_X]) begin
						best_right = in_pts;
						have_right = 1'b1;
					end
				end
				if (frame_last) begin
					if (have_left && have_right) begin
						add_lane(make_lane(SIDE_LEFT, 1'b0, best_left, 0, 1'b0));
						add_lane(make_lane(SIDE_RIGHT, 1'b0, best_right, 0, 1'b1));
					end else if (have_left) begin
						add_lane(make_lane(SIDE_LEFT, 1'b0, best_left, 0, 1'b0));
						add_lane(make_lane(SIDE_RIGHT, 1'b1, best_left, 1, 1'b1));
					end else if (have_right) begin
						add_lane(make_lane(SIDE_LEFT, 1'b1, best_right, -1, 1'b0));
						add_lane(make_lane(SIDE_RIGHT, 1'b0, best_right, 0, 1'b1));
					end
					have_left  = 1'b0;
					have_right = 1'b0;
				end
			end

			lanes_waiting  <= expected_lanes.size();
			fail_count     <= mismatches;
			lanes_compared <= compared;
			lanes_synth    <= synth_seen;
		end
	end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench top for lane_pair_selector_unit: reset, offset register loads, directed and
// random frames with bursty input and patterned output stall, and the final verdict.
// Depends on lps_pkg, lane_pair_selector_unit and lane_pair_checker.
`default_nettype none

module tb_top;
	import lps_pkg::*;

	localparam int CB           = COORD_BITS_DEF;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;

	typedef logic [NUM_POINTS-1:0][CB-1:0] spline_t;
	typedef enum int {ANY_SIDE, LEFT_ONLY, RIGHT_ONLY} side_mix_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HALF} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  has_spline;
	logic signed [CB-1:0]  start_x, start_y, second_x, second_y;
	logic signed [CB-1:0]  third_x, third_y, end_x, end_y;
	logic                  frame_last;
	logic                  out_valid;
	logic                  out_stall;
	logic                  lane_side;
	logic                  synthesized;
	logic signed [CB:0]    out_start_x, out_start_y, out_second_x, out_second_y;
	logic signed [CB:0]    out_third_x, out_third_y, out_end_x, out_end_y;
	logic                  pair_last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [OFFSET_BITS-1:0]  cfg_data;

	int lanes_waiting, fail_count, lanes_compared, lanes_synth;
	int items_sent      = 0;
	int frames_sent     = 0;
	int settings_loaded = 0;
	int burst_left      = 0;
	int hold_requests   = 0;
	bit gaps_on         = 1'b1;

	lane_pair_selector_unit #(.COORD_BITS(CB)) i_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .has_spline,
		.start_x, .start_y, .second_x, .second_y, .third_x, .third_y, .end_x, .end_y,
		.frame_last,
		.out_valid, .out_stall, .lane_side, .synthesized,
		.out_start_x, .out_start_y, .out_second_x, .out_second_y,
		.out_third_x, .out_third_y, .out_end_x, .out_end_y,
		.pair_last,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	lane_pair_checker #(.CB(CB)) i_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .has_spline,
		.start_x, .start_y, .second_x, .second_y, .third_x, .third_y, .end_x, .end_y,
		.frame_last,
		.out_valid, .out_stall, .lane_side, .synthesized,
		.out_start_x, .out_start_y, .out_second_x, .out_second_y,
		.out_third_x, .out_third_y, .out_end_x, .out_end_y,
		.pair_last,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.lanes_waiting, .fail_count, .lanes_compared, .lanes_synth
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic spline_t spline_of(int sx, int sy, int x2, int y2,
			int x3, int y3, int ex, int ey);
		spline_t s;
		s[PT_START_X] = CB'(sx);
		s[PT_START_Y] = CB'(sy);
		s[2]          = CB'(x2);
		s[3]          = CB'(y2);
		s[4]          = CB'(x3);
		s[5]          = CB'(y3);
		s[PT_END_X]   = CB'(ex);
		s[PT_END_Y]   = CB'(ey);
		return s;
	endfunction

	function automatic spline_t random_spline(side_mix_t mix, bit narrow);
		spline_t s;
		logic is_left;
		do begin
			for (int k = 0; k < NUM_POINTS; k++)
				s[k] = narrow ? CB'($urandom_range(0, 16) - 8) : CB'($urandom);
			is_left = ($signed(s[PT_END_X]) < $signed(s[PT_START_X])) &&
				($signed(s[PT_END_Y]) >= $signed(s[PT_START_Y]));
		end while ((mix == LEFT_ONLY && !is_left) || (mix == RIGHT_ONLY && is_left));
		return s;
	endfunction

	task automatic send_item(logic has, spline_t s, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on && $urandom_range(0, 1) == 1) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		has_spline <= has;
		start_x    <= s[PT_START_X];
		start_y    <= s[PT_START_Y];
		second_x   <= s[2];
		second_y   <= s[3];
		third_x    <= s[4];
		third_y    <= s[5];
		end_x      <= s[PT_END_X];
		end_y      <= s[PT_END_Y];
		frame_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(int n, side_mix_t mix);
		bit narrow;
		bit marker_end;
		narrow     = $urandom_range(0, 1);
		marker_end = (n == 0) || ($urandom_range(0, 2) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(1'b0, random_spline(ANY_SIDE, 1'b0), 1'b0);
			send_item(1'b1, random_spline(mix, narrow), (i == n - 1) && !marker_end);
		end
		if (marker_end)
			send_item(1'b0, random_spline(ANY_SIDE, 1'b0), 1'b1);
		frames_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (lanes_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_offsets(int o0, int o1, int o2, int o3);
		int vals [NUM_OFFSETS];
		vals = '{o0, o1, o2, o3};
		for (int i = 0; i < NUM_OFFSETS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data  <= OFFSET_BITS'(vals[i]);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// receiver stall pattern; a hold request forces a long stretch of stall
	initial begin
		int hold_left;
		int span;
		int holds_seen;
		stall_mode_t mode;
		hold_left  = 0;
		span       = 0;
		holds_seen = 0;
		mode       = STALL_NONE;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					span = $urandom_range(4, 64);
				end
				span--;
				unique case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	initial begin
		int target;
		int pick;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		has_spline <= 1'b0;
		start_x    <= '0;
		start_y    <= '0;
		second_x   <= '0;
		second_y   <= '0;
		third_x    <= '0;
		third_y    <= '0;
		end_x      <= '0;
		end_y      <= '0;
		frame_last <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset offsets: left only, right only (vertical), both with ties, a frame with no spline, more short frames
		send_item(1'b1, spline_of(2047, -2048, 0, 0, -1, 2047, -2048, 2047), 1'b1);
		send_item(1'b1, spline_of(-2048, 2047, -2048, -2048, 2047, 0, -2048, -2048), 1'b0);
		send_item(1'b0, spline_of(5, 5, 5, 5, 5, 5, 0, 9), 1'b1);
		send_item(1'b1, spline_of(100, 0, 7, 7, 8, 8, 0, 10), 1'b0);
		send_item(1'b1, spline_of(0, 0, 1, 1, 2, 2, 50, 10), 1'b0);
		send_item(1'b1, spline_of(100, 5, 9, 9, 9, 9, 50, 5), 1'b0);
		send_item(1'b1, spline_of(-20, 30, 3, 3, 4, 4, 50, -1), 1'b0);
		send_item(1'b0, random_spline(ANY_SIDE, 1'b0), 1'b0);
		send_item(1'b1, spline_of(101, 1, 1, 2, 3, 4, -5, 1), 1'b0);
		send_item(1'b1, spline_of(60, 60, 5, 5, 6, 6, 49, 10), 1'b1);
		send_item(1'b0, random_spline(ANY_SIDE, 1'b0), 1'b0);
		send_item(1'b0, random_spline(ANY_SIDE, 1'b0), 1'b1);
		send_item(1'b1, spline_of(10, 10, 0, 0, 0, 0, 9, 9), 1'b0);
		send_item(1'b1, spline_of(10, 10, 0, 0, 0, 0, 9, 10), 1'b1);
		send_item(1'b1, spline_of(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
		send_item(1'b1, spline_of(-1, -1, -1, -1, -1, -1, -1, -1), 1'b1);
		frames_sent += 7;

		wait_drained();
		load_offsets(1023, 1023, 1023, 1023);
		send_item(1'b1, spline_of(2047, 2047, 2047, 2047, 2047, 2047, -2048, 2047), 1'b1);
		send_item(1'b1, spline_of(-2048, -2048, -2048, -2048, -2048, -2048, 2047, 2047), 1'b1);

		wait_drained();
		load_offsets(0, 0, 0, 0);
		send_item(1'b1, spline_of(300, -7, 200, 8, 100, 9, -300, 40), 1'b1);
		send_item(1'b1, spline_of(-300, 40, -200, 9, -100, 8, 300, -7), 1'b1);
		frames_sent += 4;

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			unique case (ph)
				0:       load_offsets(1023, 0, 1023, 0);
				1:       load_offsets(0, 1023, 0, 1023);
				default: load_offsets($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
			endcase
			gaps_on = (ph != 2);
			if (ph == 3) begin
				hold_requests <= hold_requests + 1;
				repeat (40) send_frame(1, ANY_SIDE);
			end
			target = items_sent + 85;
			while (items_sent < target) begin
				pick = $urandom_range(0, 19);
				if (pick < 2)
					send_frame(0, ANY_SIDE);
				else if (pick < 5)
					send_frame($urandom_range(1, 5), LEFT_ONLY);
				else if (pick < 8)
					send_frame($urandom_range(1, 5), RIGHT_ONLY);
				else if (pick < 9)
					send_frame($urandom_range(6, 12), ANY_SIDE);
				else
					send_frame($urandom_range(1, 4), ANY_SIDE);
			end
		end
		wait_drained();

		$display("run summary: %0d input transfers in %0d frames, %0d offset settings",
			items_sent, frames_sent, settings_loaded);
		$display("run summary: %0d lanes compared, %0d of them synthesized",
			lanes_compared, lanes_synth);
		if (fail_count == 0 && lanes_waiting == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[lane_pair_selector_unit.f]
design/lps_pkg.sv
design/lane_pair_selector_unit.sv
dv/lane_pair_checker.sv
dv/tb_top.sv
